FILE: rtl/core/rla_pkg.sv
// rla_pkg: shared types and constants of the receive ring line assembler
// no dependencies; imported by every module of the block
`default_nettype none

package rla_pkg;

  // carriage return ends a line and is consumed without being emitted
  localparam logic [7:0] CHAR_CR = 8'h0D;

  // width of the consumed-entry count sent back by the line reader (holds counts up to 127)
  localparam int ADV_W = 7;

  // depth of the command queue between classifier and executor
  localparam int CMDQ_DEPTH = 2;

  typedef enum logic [0:0] {
    OP_BYTE = 1'b0,
    OP_REQ  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_CHAR   = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_NOLINE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_TAKE,
    ACT_NOLINE
  } act_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_DATA,
    BK_FLUSH
  } bk_state_e;

  // one classified item: optional store of a byte, then an optional line action
  typedef struct packed {
    logic       wr;
    logic [7:0] data;
    act_e       act;
  } cmd_t;

  // completion report of a line read
  typedef struct packed {
    logic             valid;
    logic [ADV_W-1:0] adv;
    logic             cr;
  } done_t;

endpackage

`default_nettype wire

FILE: rtl/core/rla_if.sv
// rla_if: valid/ready channel interfaces for items in and results out
// depends on nothing; used by the top level and its front and back parts
`default_nettype none

interface rla_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;
  logic       wait_for_line;

  modport source (output valid, output op, output rx_byte, output wait_for_line, input ready);
  modport sink   (input valid, input op, input rx_byte, input wait_for_line, output ready);
endinterface

interface rla_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] line_char;
  logic       last;

  modport source (output valid, output status, output line_char, output last, input ready);
  modport sink   (input valid, input status, input line_char, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/rla_front.sv
// rla_front: accepts items, tracks fill level and stored carriage returns,
// decides store/drop and line completion; depends on rla_pkg and rla_in_if
`default_nettype none

module rla_front #(
  parameter int BUF_DEPTH = 128,
  parameter int LINE_MAX  = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  rla_in_if.sink         in_i,
  output rla_pkg::cmd_t  cmd_o,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i,
  input  rla_pkg::done_t done_i
);
  import rla_pkg::*;

  localparam int OW = $clog2(BUF_DEPTH);

  logic [OW-1:0] occ_q, occ_d;
  logic [OW-1:0] cr_cnt_q, cr_cnt_d;
  logic          pending_q, pending_d;
  logic          busy_q, busy_d;
  logic          accept;
  logic          store;
  logic          complete;

  // no new item while a line read is in flight: its length is unknown until done
  assign in_i.ready = !busy_q && cmd_ready_i;
  assign accept     = in_i.valid && in_i.ready;
  assign store      = (occ_q != OW'(BUF_DEPTH - 1));

  always_comb begin
    occ_d       = occ_q;
    cr_cnt_d    = cr_cnt_q;
    pending_d   = pending_q;
    busy_d      = busy_q;
    cmd_o.wr    = 1'b0;
    cmd_o.data  = in_i.rx_byte;
    cmd_o.act   = ACT_NONE;
    cmd_valid_o = 1'b0;
    complete    = 1'b0;

    if (done_i.valid) begin
      occ_d    = occ_q - OW'(done_i.adv);
      cr_cnt_d = cr_cnt_q - {{(OW-1){1'b0}}, done_i.cr};
      busy_d   = 1'b0;
    end

    if (accept) begin
      if (op_e'(in_i.op) == OP_BYTE) begin
        if (store) begin
          cmd_o.wr = 1'b1;
          occ_d    = occ_q + {{(OW-1){1'b0}}, 1'b1};
          if (in_i.rx_byte == CHAR_CR) begin
            cr_cnt_d = cr_cnt_q + {{(OW-1){1'b0}}, 1'b1};
          end
        end
        complete = (cr_cnt_d != '0) || (32'(occ_d) >= 32'(LINE_MAX - 1));
        if (pending_q && complete) begin
          cmd_o.act = ACT_TAKE;
          pending_d = 1'b0;
          busy_d    = 1'b1;
        end
        cmd_valid_o = cmd_o.wr || (cmd_o.act != ACT_NONE);
      end else begin
        complete = (cr_cnt_q != '0) || (32'(occ_q) >= 32'(LINE_MAX - 1));
        if (complete) begin
          cmd_o.act   = ACT_TAKE;
          cmd_valid_o = 1'b1;
          pending_d   = 1'b0;
          busy_d      = 1'b1;
        end else if (in_i.wait_for_line) begin
          pending_d = 1'b1;
        end else begin
          cmd_o.act   = ACT_NOLINE;
          cmd_valid_o = 1'b1;
          pending_d   = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q     <= '0;
      cr_cnt_q  <= '0;
      pending_q <= 1'b0;
      busy_q    <= 1'b0;
    end else begin
      occ_q     <= occ_d;
      cr_cnt_q  <= cr_cnt_d;
      pending_q <= pending_d;
      busy_q    <= busy_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rla_cmd_fifo.sv
// rla_cmd_fifo: short command queue between the front and back parts
// depends on rla_pkg
`default_nettype none

module rla_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rla_pkg::cmd_t wr_data_i,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  output rla_pkg::cmd_t rd_data_o,
  output logic          rd_valid_o,
  input  logic          rd_ready_i
);
  import rla_pkg::*;

  localparam int PW = $clog2(CMDQ_DEPTH);
  localparam int CW = $clog2(CMDQ_DEPTH + 1);

  cmd_t          slot_q [CMDQ_DEPTH];
  logic [PW-1:0] wp_q, wp_d;
  logic [PW-1:0] rp_q, rp_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          push, pop;

  assign wr_ready_o = (cnt_q != CW'(CMDQ_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = slot_q[rp_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push) begin
      wp_d = (wp_q == PW'(CMDQ_DEPTH - 1)) ? '0 : wp_q + 1'b1;
    end
    if (pop) begin
      rp_d = (rp_q == PW'(CMDQ_DEPTH - 1)) ? '0 : rp_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wp_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rla_back.sv
// rla_back: ring store and line reader; stores bytes, walks a line out of the
// store through a registered read, drives the result register; depends on rla_pkg, rla_out_if
`default_nettype none

module rla_back #(
  parameter int BUF_DEPTH = 128,
  parameter int LINE_MAX  = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rla_pkg::cmd_t  cmd_i,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  output rla_pkg::done_t done_o,
  rla_out_if.source      out_o
);
  import rla_pkg::*;

  localparam int IW = $clog2(BUF_DEPTH);
  localparam int CW = $clog2(LINE_MAX);

  logic [7:0]    ring_q [BUF_DEPTH];
  logic [7:0]    rd_data_q;
  logic [IW-1:0] wptr_q, wptr_d;
  logic [IW-1:0] rptr_q, rptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [7:0]    hold_q, hold_d;
  logic          hold_v_q, hold_v_d;
  bk_state_e     state_q, state_d;

  logic          out_valid_q, out_valid_d;
  status_e       out_status_q, out_status_d;
  logic [7:0]    out_char_q, out_char_d;
  logic          out_last_q, out_last_d;

  logic          slot_free;
  logic          ld;
  logic          pop;
  logic          mem_we;

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] p);
    return (p == IW'(BUF_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign slot_free   = !out_valid_q || out_o.ready;
  assign cmd_ready_o = (state_q == BK_IDLE) && slot_free;
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign mem_we      = pop && cmd_i.wr;

  always_comb begin
    state_d      = state_q;
    wptr_d       = wptr_q;
    rptr_d       = rptr_q;
    cnt_d        = cnt_q;
    hold_d       = hold_q;
    hold_v_d     = hold_v_q;
    ld           = 1'b0;
    out_status_d = out_status_q;
    out_char_d   = out_char_q;
    out_last_d   = out_last_q;
    done_o       = '0;

    case (state_q)
      BK_IDLE: begin
        if (pop) begin
          if (cmd_i.wr) begin
            wptr_d = ring_next(wptr_q);
          end
          case (cmd_i.act)
            ACT_NOLINE: begin
              ld           = 1'b1;
              out_status_d = ST_NOLINE;
              out_char_d   = '0;
              out_last_d   = 1'b0;
            end
            ACT_TAKE: begin
              rptr_d   = ring_next(rptr_q);
              cnt_d    = '0;
              hold_v_d = 1'b0;
              state_d  = BK_READ;
            end
            default: ;
          endcase
        end
      end
      BK_READ: begin
        state_d = BK_DATA;
      end
      BK_DATA: begin
        if (rd_data_q == CHAR_CR) begin
          if (slot_free) begin
            ld           = 1'b1;
            out_status_d = hold_v_q ? ST_CHAR : ST_EMPTY;
            out_char_d   = hold_v_q ? hold_q : 8'h00;
            out_last_d   = 1'b1;
            done_o.valid = 1'b1;
            done_o.adv   = ADV_W'(cnt_q) + ADV_W'(1);
            done_o.cr    = 1'b1;
            state_d      = BK_IDLE;
          end
        end else if (!hold_v_q || slot_free) begin
          if (hold_v_q) begin
            ld           = 1'b1;
            out_status_d = ST_CHAR;
            out_char_d   = hold_q;
            out_last_d   = 1'b0;
          end
          hold_d   = rd_data_q;
          hold_v_d = 1'b1;
          cnt_d    = cnt_q + 1'b1;
          if (32'(cnt_q) + 32'd1 == 32'(LINE_MAX - 1)) begin
            state_d = BK_FLUSH;
          end else begin
            rptr_d  = ring_next(rptr_q);
            state_d = BK_READ;
          end
        end
      end
      BK_FLUSH: begin
        // line reached its length limit: last held character closes it
        if (slot_free) begin
          ld           = 1'b1;
          out_status_d = ST_CHAR;
          out_char_d   = hold_q;
          out_last_d   = 1'b1;
          done_o.valid = 1'b1;
          done_o.adv   = ADV_W'(cnt_q);
          done_o.cr    = 1'b0;
          state_d      = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase

    if (ld) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_q[ring_next(wptr_q)] <= cmd_i.data;
    end
    if (state_q == BK_READ) begin
      rd_data_q <= ring_q[rptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q       <= hold_d;
    out_status_q <= out_status_d;
    out_char_q   <= out_char_d;
    out_last_q   <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      wptr_q      <= '0;
      rptr_q      <= '0;
      cnt_q       <= '0;
      hold_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wptr_q      <= wptr_d;
      rptr_q      <= rptr_d;
      cnt_q       <= cnt_d;
      hold_v_q    <= hold_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_status_q;
  assign out_o.line_char = out_char_q;
  assign out_o.last      = out_last_q;

endmodule

`default_nettype wire

FILE: rtl/core/rx_ring_line_assembler.sv
// rx_ring_line_assembler: receive ring store with a read-line front end
// path: front, command queue, back; a byte is written to the ring, a no-line answer is loaded
//   into the result register, a line is walked out through registered reads (result stalls delay all)
// throughput: bytes and no-line answers 1 per cycle while results are taken and no line read is
//   in flight; a line read holds the input until it completes, also when it ends at the length limit
// reset: rst_ni async active low clears indexes, counts and pending flag; ring store uncleared
`default_nettype none

module rx_ring_line_assembler #(
  parameter int BUF_DEPTH = 128,
  parameter int LINE_MAX  = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rla_in_if.sink     in_i,
  rla_out_if.source  out_o
);
  import rla_pkg::*;

  // front to queue
  cmd_t  fr_cmd;
  logic  fr_valid;
  logic  fr_ready;

  // queue to back
  cmd_t  bk_cmd;
  logic  bk_valid;
  logic  bk_ready;

  // line read completion, back to front: entries consumed and whether a cr went with them
  done_t done;

  // front: store/drop decision from the fill count, line completion from the
  // count of stored carriage returns and the fill count, so no scan is needed to decide
  rla_front #(
    .BUF_DEPTH (BUF_DEPTH),
    .LINE_MAX  (LINE_MAX)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_o       (fr_cmd),
    .cmd_valid_o (fr_valid),
    .cmd_ready_i (fr_ready),
    .done_i      (done)
  );

  // short queue so the front keeps taking bytes while the back drains results
  rla_cmd_fifo u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_data_i  (fr_cmd),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .rd_data_o  (bk_cmd),
    .rd_valid_o (bk_valid),
    .rd_ready_i (bk_ready)
  );

  // back: ring memory, write index, read index and the line walk
  rla_back #(
    .BUF_DEPTH (BUF_DEPTH),
    .LINE_MAX  (LINE_MAX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (bk_cmd),
    .cmd_valid_i (bk_valid),
    .cmd_ready_o (bk_ready),
    .done_o      (done),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/rla_checker.sv
// rla_checker: port-level checks of the result channel, bound to the top level
// depends on rla_pkg and rx_ring_line_assembler
`default_nettype none

module rla_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] out_status_i,
  input logic [7:0] out_char_i,
  input logic       out_last_i
);
  import rla_pkg::*;

  // a result waiting on the sink stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // only the three defined status codes appear
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_status_i == ST_CHAR || out_status_i == ST_EMPTY ||
                     out_status_i == ST_NOLINE))
    else $error("undefined status code");

  // a no-line answer carries no character and no last flag
  a_noline_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == ST_NOLINE |-> !out_last_i && out_char_i == 8'h00)
    else $error("malformed no-line result");

  // an empty line is a single result that closes the line
  a_empty_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == ST_EMPTY |-> out_last_i && out_char_i == 8'h00)
    else $error("malformed empty-line result");

endmodule

bind rx_ring_line_assembler rla_checker u_rla_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_char_i   (out_o.line_char),
  .out_last_i   (out_o.last)
);

`default_nettype wire

FILE: sim/testbench.sv
// testbench: self-checking bench for rx_ring_line_assembler, with its own line-reader predictor
// depends on rla_pkg (codes, carriage return) and the rla_in_if / rla_out_if channels
// directed cases, the length limit, the full store, random phases with idling, output hold-off
`default_nettype none

module testbench;
  import rla_pkg::*;

  localparam int RING_DEPTH = 128;
  localparam int LINE_LEN   = 64;
  localparam int IDLE_LIMIT = 3000;
  localparam int TAIL_WAIT  = 200;

  typedef struct packed {
    status_e    status;
    logic [7:0] ch;
    logic       last;
  } line_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rla_in_if  in_if ();
  rla_out_if out_if ();

  rx_ring_line_assembler #(
    .BUF_DEPTH(RING_DEPTH),
    .LINE_MAX (LINE_LEN)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [7:0]  ring_mem [RING_DEPTH];
  int unsigned wr_ptr = 0;
  int unsigned rd_ptr = 0;
  bit          req_waiting = 1'b0;
  line_res_t   line_q[$];

  // knobs and tallies
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int err_cnt = 0;
  int n_items = 0;
  int n_bytes = 0;
  int n_drops = 0;
  int n_reqs = 0;
  int n_lines = 0;
  int n_empty = 0;
  int n_noline = 0;
  int n_checked = 0;
  int idle_cnt = 0;

  function automatic int unsigned ring_inc(int unsigned i);
    return (i >= RING_DEPTH - 1) ? 0 : i + 1;
  endfunction

  // queue the next complete line, if there is one; nothing is consumed otherwise
  function automatic bit pop_line();
    int unsigned pos;
    logic [7:0]  c;
    logic [7:0]  chars[$];
    bit          found;
    bit          stop;
    pos = rd_ptr;
    found = 1'b0;
    stop = 1'b0;
    while (!stop) begin
      if (pos == wr_ptr) begin
        stop = 1'b1;
      end else begin
        pos = ring_inc(pos);
        c = ring_mem[pos];
        if (c == CHAR_CR) begin
          found = 1'b1;
          stop = 1'b1;
        end else begin
          chars.push_back(c);
          if (chars.size() >= LINE_LEN - 1) begin
            found = 1'b1;
            stop = 1'b1;
          end
        end
      end
    end
    if (!found) return 1'b0;
    rd_ptr = pos;
    if (chars.size() == 0) begin
      line_q.push_back('{ST_EMPTY, 8'h00, 1'b1});
      n_empty++;
    end else begin
      foreach (chars[k]) line_q.push_back('{ST_CHAR, chars[k], k == chars.size() - 1});
      n_lines++;
    end
    return 1'b1;
  endfunction

  function automatic void apply_item(op_e op, logic [7:0] b, logic w);
    int unsigned nxt;
    if (op == OP_BYTE) begin
      n_bytes++;
      nxt = ring_inc(wr_ptr);
      if (nxt != rd_ptr) begin
        ring_mem[nxt] = b;
        wr_ptr = nxt;
      end else begin
        n_drops++;
      end
      if (req_waiting && pop_line()) req_waiting = 1'b0;
    end else begin
      n_reqs++;
      if (pop_line()) begin
        req_waiting = 1'b0;
      end else if (w) begin
        req_waiting = 1'b1;
      end else begin
        req_waiting = 1'b0;
        line_q.push_back('{ST_NOLINE, 8'h00, 1'b0});
        n_noline++;
      end
    end
  endfunction

  // one item on the input channel; returns just after the accepting edge
  task automatic send_item(input op_e op, input logic [7:0] b, input logic w);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.op            <= op;
    in_if.rx_byte       <= b;
    in_if.wait_for_line <= w;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    apply_item(op, b, w);
    n_items++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(OP_BYTE, b, 1'($urandom_range(1)));
  endtask

  task automatic send_req(input logic w);
    send_item(OP_REQ, 8'($urandom_range(255)), w);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CHAR_CR);
    return b;
  endfunction

  task automatic send_text(input int len, input bit with_cr);
    for (int i = 0; i < len; i++) send_byte(plain_char());
    if (with_cr) send_byte(CHAR_CR);
  endtask

  task automatic release_input();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
  endtask

  // stop offering the last item before waiting, so it is not taken twice
  task automatic wait_drained();
    release_input();
    while (line_q.size() != 0) @(posedge clk_i);
  endtask

  // result side: ready pattern per cycle, or a long hold-off when asked
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_if.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // result checker against the oldest expectation
  always @(posedge clk_i) begin
    line_res_t exp_res;
    if (out_if.valid && out_if.ready) begin
      if (line_q.size() == 0) begin
        $error("unexpected result: status %0d char %h last %0b",
               out_if.status, out_if.line_char, out_if.last);
        err_cnt++;
      end else begin
        exp_res = line_q.pop_front();
        n_checked++;
        if (out_if.status !== exp_res.status) begin
          $error("status: expected %0d, actual %0d", exp_res.status, out_if.status);
          err_cnt++;
        end
        if (out_if.line_char !== exp_res.ch) begin
          $error("line_char: expected %h, actual %h", exp_res.ch, out_if.line_char);
          err_cnt++;
        end
        if (out_if.last !== exp_res.last) begin
          $error("last: expected %0b, actual %0b", exp_res.last, out_if.last);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted item or taken result
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt + 1 >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // miss on empty store, pending completion, empty line, replacement, partial line
  task automatic test_directed();
    send_req(1'b0);
    send_req(1'b1);
    send_item(OP_BYTE, 8'h41, 1'b1);
    send_item(OP_BYTE, 8'h00, 1'b0);
    send_item(OP_BYTE, 8'hFF, 1'b1);
    send_byte(CHAR_CR);
    send_byte(CHAR_CR);
    send_item(OP_REQ, 8'h00, 1'b0);
    send_item(OP_REQ, 8'hFF, 1'b1);
    send_req(1'b0);
    send_req(1'b1);
    send_req(1'b1);
    send_byte(8'h78);
    send_byte(CHAR_CR);
    send_byte(8'h61);
    send_byte(8'h62);
    send_req(1'b0);
    send_byte(CHAR_CR);
    send_req(1'b0);
    wait_drained();
  endtask

  // a blocking request completed by the length limit
  task automatic test_length_limit();
    send_req(1'b1);
    send_text(LINE_LEN - 1, 1'b0);
    wait_drained();
  endtask

  // fill the ring with a full-length line, its carriage return and a second
  // full-length line, one byte dropped, then drain it line by line
  task automatic test_full_store();
    send_text(LINE_LEN - 1, 1'b1);
    send_text(RING_DEPTH - LINE_LEN, 1'b0);
    send_req(1'b0);
    send_req(1'b0);
    send_req(1'b0);
    send_req(1'b0);
    send_req(1'b1);
    send_byte(CHAR_CR);
    wait_drained();
  endtask

  // mostly well-formed lines with random content, plus loose requests and raw bytes
  task automatic run_random(input int target);
    int first;
    int pick;
    first = n_items;
    while (n_items - first < target) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        if ($urandom_range(3) == 0) send_req(1'b1);
        send_text($urandom_range(8), $urandom_range(6) != 0);
        send_req(1'($urandom_range(1)));
      end else if (pick < 85) begin
        send_req(1'($urandom_range(1)));
      end else begin
        send_byte(8'($urandom_range(255)));
      end
    end
    wait_drained();
  endtask

  task automatic test_random_phases();
    send_idle_pct = 0;  recv_stall_pct = 0;  run_random(5);
    send_idle_pct = 52; recv_stall_pct = 0;  run_random(5);
    send_idle_pct = 0;  recv_stall_pct = 52; run_random(5);
    send_idle_pct = 20; recv_stall_pct = 20; run_random(5);
  endtask

  // results held back for a long stretch so the block backs up into its input
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 300;
    for (int i = 0; i < 3; i++) begin
      send_text(4, 1'b1);
      send_req(1'b0);
    end
    wait_drained();
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.op = OP_BYTE;
    in_if.rx_byte = 8'h00;
    in_if.wait_for_line = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    test_directed();
    test_length_limit();
    test_full_store();
    test_random_phases();
    test_backpressure();
    release_input();

    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk_i);

    $display("covered %0d items: %0d bytes (%0d dropped on a full ring), %0d read requests",
             n_items, n_bytes, n_drops, n_reqs);
    $display("checked %0d results: %0d lines, %0d empty lines, %0d no-line answers",
             n_checked, n_lines, n_empty, n_noline);
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/core/rla_pkg.sv
rtl/core/rla_if.sv
rtl/core/rla_front.sv
rtl/core/rla_cmd_fifo.sv
rtl/core/rla_back.sv
rtl/core/rx_ring_line_assembler.sv
rtl/core/rla_checker.sv
sim/testbench.sv
